FILE: sv/d2c_pkg.sv
// d2c_pkg: shared types, widths and constants of the depth-to-color registration block
// used by d2c_div, d2c_dp, d2c_ctrl and depth_to_color_registration; no dependencies

package d2c_pkg;

  // field widths
  localparam int COL_W   = 11;
  localparam int ROW_W   = 10;
  localparam int DEPTH_W = 16;

  // stream packing (tdata, lowest field first)
  localparam int IN_COL_LSB    = 0;
  localparam int IN_ROW_LSB    = IN_COL_LSB + COL_W;
  localparam int IN_DEPTH_LSB  = IN_ROW_LSB + ROW_W;
  localparam int IN_TDATA_W    = ((IN_DEPTH_LSB + DEPTH_W + 7) / 8) * 8;
  localparam int OUT_ROW_LSB   = 0;
  localparam int OUT_FIRST_LSB = OUT_ROW_LSB + ROW_W;
  localparam int OUT_LAST_LSB  = OUT_FIRST_LSB + COL_W;
  localparam int OUT_DEPTH_LSB = OUT_LAST_LSB + COL_W;
  localparam int OUT_TDATA_W   = ((OUT_DEPTH_LSB + DEPTH_W + 7) / 8) * 8;

  // coefficient registers, signed Q11.20
  localparam int COEF_W    = 32;
  localparam int NUM_COEF  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 20;

  // inverse depth: floor(65535 * 2^16 / depth), unsigned Q16.16
  localparam int INV_W     = 32;
  localparam int INV_SHIFT = 16;
  localparam logic [INV_W-1:0] INV_NUM = 32'hFFFF_0000;

  // multiplier and accumulator
  localparam int MUL_W   = COEF_W + 1;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = 50;
  localparam int INT_W   = ACC_W - FRAC_W;
  localparam int COORD_W = 13;
  localparam logic [ACC_W-1:0] FRAC_ROUND = ACC_W'((64'd1 << FRAC_W) - 64'd1);

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t coef_arr_t [NUM_COEF];

  localparam coef_arr_t COEF_RESET = '{
    32'sd1048601, -32'sd225,     32'sd8620,   -32'sd18510075,
    32'sd69,      32'sd1048480,  32'sd362043, -32'sd7408
  };

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COL_FROM_COL  = 3'd0,
    REG_COL_FROM_ROW  = 3'd1,
    REG_COL_OFFSET    = 3'd2,
    REG_COL_INV_DEPTH = 3'd3,
    REG_ROW_FROM_COL  = 3'd4,
    REG_ROW_FROM_ROW  = 3'd5,
    REG_ROW_OFFSET    = 3'd6,
    REG_ROW_INV_DEPTH = 3'd7
  } cfg_reg_e;

  // product terms of the two axis sums
  typedef enum logic [2:0] {
    TERM_COL_COL = 3'd0,
    TERM_COL_ROW = 3'd1,
    TERM_ROW_COL = 3'd2,
    TERM_ROW_ROW = 3'd3,
    TERM_COL_INV = 3'd4,
    TERM_ROW_INV = 3'd5
  } term_e;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_CHECK    = 3'd1,
    ST_LIN      = 3'd2,
    ST_DIV_WAIT = 3'd3,
    ST_INV      = 3'd4,
    ST_FINISH   = 3'd5,
    ST_EMIT     = 3'd6
  } ctrl_state_e;

  typedef struct packed {
    logic  accept;
    logic  load_acc;
    logic  div_start;
    logic  mul_en;
    logic  acc_en;
    term_e term;
    logic  finish;
    logic  emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic depth_zero;
    logic div_busy;
    logic in_range;
    logic out_free;
  } ctrl_status_t;

  // coefficient that weighs a term
  function automatic cfg_reg_e term_reg(term_e t);
    cfg_reg_e r;
    case (t)
      TERM_COL_COL: r = REG_COL_FROM_COL;
      TERM_COL_ROW: r = REG_COL_FROM_ROW;
      TERM_ROW_COL: r = REG_ROW_FROM_COL;
      TERM_ROW_ROW: r = REG_ROW_FROM_ROW;
      TERM_COL_INV: r = REG_COL_INV_DEPTH;
      TERM_ROW_INV: r = REG_ROW_INV_DEPTH;
      default:      r = REG_COL_FROM_COL;
    endcase
    return r;
  endfunction

  function automatic logic term_is_inv(term_e t);
    return (t == TERM_COL_INV) || (t == TERM_ROW_INV);
  endfunction

  function automatic logic term_is_row_axis(term_e t);
    return (t == TERM_ROW_COL) || (t == TERM_ROW_ROW) || (t == TERM_ROW_INV);
  endfunction

  function automatic logic term_uses_col(term_e t);
    return (t == TERM_COL_COL) || (t == TERM_ROW_COL);
  endfunction

endpackage

FILE: sv/d2c_div.sv
// d2c_div: radix-2 restoring divider for the inverse depth, one quotient bit per cycle
// depends on d2c_pkg

module d2c_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [d2c_pkg::DEPTH_W-1:0]   divisor_i,
  output logic                          busy_o,
  output logic [d2c_pkg::INV_W-1:0]     quot_o
);

  localparam int CNT_W = $clog2(d2c_pkg::INV_W + 1);

  logic [d2c_pkg::INV_W-1:0]   q_q, q_d;
  logic [d2c_pkg::DEPTH_W-1:0] rem_q, rem_d;
  logic [d2c_pkg::DEPTH_W-1:0] dvs_q;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic [d2c_pkg::DEPTH_W:0]   partial;
  logic [d2c_pkg::DEPTH_W+1:0] diff;
  logic                        qbit;

  // start load, or one shift-subtract step while busy
  always_comb begin
    partial = {rem_q, q_q[d2c_pkg::INV_W-1]};
    diff    = {1'b0, partial} - {2'b00, dvs_q};
    qbit    = ~diff[d2c_pkg::DEPTH_W+1];
    q_d     = q_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (start_i) begin
      q_d    = d2c_pkg::INV_NUM;
      rem_d  = '0;
      cnt_d  = CNT_W'(d2c_pkg::INV_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      q_d    = {q_q[d2c_pkg::INV_W-2:0], qbit};
      rem_d  = qbit ? diff[d2c_pkg::DEPTH_W-1:0] : partial[d2c_pkg::DEPTH_W-1:0];
      cnt_d  = cnt_q - CNT_W'(1);
      busy_d = (cnt_q != CNT_W'(1));
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // quotient, remainder and divisor
  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = q_q;

endmodule

FILE: sv/d2c_dp.sv
// d2c_dp: datapath with coefficient registers, pixel latch, shared multiplier,
// axis accumulators, range check, span logic and output register; uses d2c_div, d2c_pkg

module d2c_dp #(
  parameter int IMG_WIDTH  = 1280,
  parameter int IMG_HEIGHT = 720
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [d2c_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [d2c_pkg::COEF_W-1:0]        cfg_data_i,
  input  logic [d2c_pkg::IN_TDATA_W-1:0]    in_data_i,
  input  logic                              in_start_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [d2c_pkg::OUT_TDATA_W-1:0]   out_data_o,
  input  d2c_pkg::ctrl_cmd_t                cmd_i,
  output d2c_pkg::ctrl_status_t             status_o
);

  localparam int ACC_W   = d2c_pkg::ACC_W;
  localparam int COEF_W  = d2c_pkg::COEF_W;
  localparam int MUL_W   = d2c_pkg::MUL_W;
  localparam int INT_W   = d2c_pkg::INT_W;
  localparam int COORD_W = d2c_pkg::COORD_W;

  d2c_pkg::coef_t                coef_q [d2c_pkg::NUM_COEF];
  logic [d2c_pkg::COL_W-1:0]     col_q;
  logic [d2c_pkg::ROW_W-1:0]     row_q;
  logic [d2c_pkg::DEPTH_W-1:0]   depth_q;
  logic [d2c_pkg::COL_W-1:0]     last_q;
  logic [d2c_pkg::INV_W-1:0]     inv;
  logic                          div_busy;

  logic signed [d2c_pkg::PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]           acc_col_q, acc_row_q;
  logic [COORD_W-1:0]                tc_q, tr_q;
  logic                              ok_q;
  logic                              out_valid_q;
  logic [d2c_pkg::OUT_TDATA_W-1:0]   out_data_q;

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < d2c_pkg::NUM_COEF; i++) begin
        coef_q[i] <= d2c_pkg::COEF_RESET[i];
      end
    end else if (cfg_we_i) begin
      coef_q[cfg_addr_i] <= cfg_data_i;
    end
  end

  // pixel latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      col_q   <= in_data_i[d2c_pkg::IN_COL_LSB +: d2c_pkg::COL_W];
      row_q   <= in_data_i[d2c_pkg::IN_ROW_LSB +: d2c_pkg::ROW_W];
      depth_q <= in_data_i[d2c_pkg::IN_DEPTH_LSB +: d2c_pkg::DEPTH_W];
    end
  end

  // inverse depth
  d2c_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .divisor_i (depth_q),
    .busy_o    (div_busy),
    .quot_o    (inv)
  );

  // operand selection for the shared multiplier
  d2c_pkg::coef_t          sel_coef;
  logic                    sel_inv;
  logic                    sel_neg;
  logic signed [MUL_W-1:0] coef_ext;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod;

  always_comb begin
    sel_coef = coef_q[d2c_pkg::term_reg(cmd_i.term)];
    sel_inv  = d2c_pkg::term_is_inv(cmd_i.term);
    sel_neg  = sel_inv && sel_coef[COEF_W-1];
    coef_ext = {sel_coef[COEF_W-1], sel_coef};
    if (sel_inv) begin
      // magnitude times inverse depth, sign applied after the shift
      mul_a = sel_neg ? (MUL_W'(0) - coef_ext) : coef_ext;
      mul_b = $signed({{(MUL_W-d2c_pkg::INV_W){1'b0}}, inv});
    end else if (d2c_pkg::term_uses_col(cmd_i.term)) begin
      mul_a = coef_ext;
      mul_b = $signed({{(MUL_W-d2c_pkg::COL_W){1'b0}}, col_q});
    end else begin
      mul_a = coef_ext;
      mul_b = $signed({{(MUL_W-d2c_pkg::ROW_W){1'b0}}, row_q});
    end
    prod = mul_a * mul_b;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod[d2c_pkg::PROD_W-1:0];
    end
  end

  // accumulate one term, a negated term as ones complement plus carry
  logic signed [ACC_W-1:0] term_val, addend, acc_sel, acc_sum;

  always_comb begin
    if (sel_inv) begin
      term_val = prod_q[d2c_pkg::INV_SHIFT +: ACC_W];
    end else begin
      term_val = prod_q[ACC_W-1:0];
    end
    addend  = sel_neg ? ~term_val : term_val;
    acc_sel = d2c_pkg::term_is_row_axis(cmd_i.term) ? acc_row_q : acc_col_q;
    acc_sum = acc_sel + addend + {{(ACC_W-1){1'b0}}, sel_neg};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_acc) begin
      acc_col_q <= {{(ACC_W-COEF_W){coef_q[d2c_pkg::REG_COL_OFFSET][COEF_W-1]}},
                    coef_q[d2c_pkg::REG_COL_OFFSET]};
      acc_row_q <= {{(ACC_W-COEF_W){coef_q[d2c_pkg::REG_ROW_OFFSET][COEF_W-1]}},
                    coef_q[d2c_pkg::REG_ROW_OFFSET]};
    end else if (cmd_i.acc_en) begin
      if (d2c_pkg::term_is_row_axis(cmd_i.term)) begin
        acc_row_q <= acc_sum;
      end else begin
        acc_col_q <= acc_sum;
      end
    end
  end

  // truncate toward zero to integer and check bounds
  logic [ACC_W-1:0] adj_col, adj_row;
  logic [INT_W-1:0] int_col, int_row;
  logic             col_ok, row_ok;

  always_comb begin
    adj_col = acc_col_q + (acc_col_q[ACC_W-1] ? d2c_pkg::FRAC_ROUND : '0);
    adj_row = acc_row_q + (acc_row_q[ACC_W-1] ? d2c_pkg::FRAC_ROUND : '0);
    int_col = adj_col[ACC_W-1:d2c_pkg::FRAC_W];
    int_row = adj_row[ACC_W-1:d2c_pkg::FRAC_W];
    col_ok  = !int_col[INT_W-1] && (int_col < INT_W'(IMG_WIDTH));
    row_ok  = !int_row[INT_W-1] && (int_row < INT_W'(IMG_HEIGHT));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      tc_q <= int_col[COORD_W-1:0];
      tr_q <= int_row[COORD_W-1:0];
      ok_q <= col_ok && row_ok;
    end
  end

  // span start: fill the gap after the last mapped column
  logic [COORD_W-1:0]        last_plus;
  logic [COORD_W-1:0]        first;

  always_comb begin
    last_plus = {{(COORD_W-d2c_pkg::COL_W){1'b0}}, last_q} + COORD_W'(1);
    first     = (tc_q > last_plus) ? last_plus : tc_q;
  end

  // last mapped column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (cmd_i.accept && in_start_i) begin
      last_q <= '0;
    end else if (cmd_i.emit) begin
      last_q <= tc_q[d2c_pkg::COL_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // span fields packed lowest first, zero fill above
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= d2c_pkg::OUT_TDATA_W'({depth_q,
                                           tc_q[d2c_pkg::COL_W-1:0],
                                           first[d2c_pkg::COL_W-1:0],
                                           tr_q[d2c_pkg::ROW_W-1:0]});
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // status to the controller
  always_comb begin
    status_o.depth_zero = (depth_q == '0);
    status_o.div_busy   = div_busy;
    status_o.in_range   = ok_q;
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

FILE: sv/d2c_ctrl.sv
// d2c_ctrl: controller state machine that sequences accept, divide, multiply-accumulate,
// bounds check and span emit; depends on d2c_pkg

module d2c_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output d2c_pkg::ctrl_cmd_t    cmd_o,
  input  d2c_pkg::ctrl_status_t status_i
);

  d2c_pkg::ctrl_state_e state_q, state_d;
  logic [2:0]           cnt_q, cnt_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= d2c_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.term = d2c_pkg::TERM_COL_COL;
    case (state_q)
      d2c_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = d2c_pkg::ST_CHECK;
        end
      end
      d2c_pkg::ST_CHECK: begin
        // zero depth ends the transaction without a result
        if (status_i.depth_zero) begin
          state_d = d2c_pkg::ST_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.load_acc  = 1'b1;
          cnt_d           = '0;
          state_d         = d2c_pkg::ST_LIN;
        end
      end
      d2c_pkg::ST_LIN: begin
        // column and row terms of both axes while the divider runs
        cmd_o.term   = d2c_pkg::term_e'({1'b0, cnt_q[2:1]});
        cmd_o.mul_en = !cnt_q[0];
        cmd_o.acc_en = cnt_q[0];
        cnt_d        = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = d2c_pkg::ST_DIV_WAIT;
        end
      end
      d2c_pkg::ST_DIV_WAIT: begin
        cnt_d = '0;
        if (!status_i.div_busy) begin
          state_d = d2c_pkg::ST_INV;
        end
      end
      d2c_pkg::ST_INV: begin
        // inverse depth terms
        cmd_o.term   = cnt_q[1] ? d2c_pkg::TERM_ROW_INV : d2c_pkg::TERM_COL_INV;
        cmd_o.mul_en = !cnt_q[0];
        cmd_o.acc_en = cnt_q[0];
        cnt_d        = cnt_q + 3'd1;
        if (cnt_q == 3'd3) begin
          state_d = d2c_pkg::ST_FINISH;
        end
      end
      d2c_pkg::ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = d2c_pkg::ST_EMIT;
      end
      d2c_pkg::ST_EMIT: begin
        if (!status_i.in_range) begin
          state_d = d2c_pkg::ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = d2c_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = d2c_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/depth_to_color_registration.sv
// depth_to_color_registration: maps depth pixels into color-image write spans
// top level; depends on d2c_pkg, d2c_ctrl, d2c_dp (which holds d2c_div)
//
//   channel   direction  handshake               payload
//   s_axis    in         tvalid / tready         tdata: src_col, src_row, depth_value
//                                                tuser: frame_start
//   m_axis    out        tvalid / tready         tdata: dst_row, span_first, span_last,
//                                                       span_depth
//   cfg       in         cfg_we_i                cfg_addr_i, cfg_data_i
//
// a pixel with nonzero depth goes from accept through a depth check, the column and row
// multiply-accumulate terms while the inverse depth divider runs, a wait for the divider,
// the multiply-accumulate of the inverse terms, the bounds check and the emit;
// a zero-depth pixel ends at the depth check without a result
// the finished span sits in an output register, so a stalled m_axis only holds the next
// pixel at its emit step; reset restores the calibration coefficients and clears the
// last mapped column

module depth_to_color_registration #(
  parameter int IMG_WIDTH  = 1280,
  parameter int IMG_HEIGHT = 720
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [d2c_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [d2c_pkg::COEF_W-1:0]        cfg_data_i,
  // depth pixels
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // src_col [10:0], src_row [20:11], depth_value [36:21], zero fill [39:37]
  input  logic [d2c_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // frame_start [0]
  input  logic [0:0]                        s_axis_tuser,
  // write spans
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // dst_row [9:0], span_first [20:10], span_last [31:21], span_depth [47:32]
  output logic [d2c_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  d2c_pkg::ctrl_cmd_t    cmd;
  d2c_pkg::ctrl_status_t status;

  // sequencer
  d2c_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // arithmetic and storage
  d2c_dp #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_start_i  (s_axis_tuser[0]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

FILE: test/tb.sv
// tb: self-checking regression for depth_to_color_registration, stream in, span out
// depends on d2c_pkg and the depth_to_color_registration rtl; holds its own span predictor

module tb;
  import d2c_pkg::*;

  localparam int IMG_W           = 1280;
  localparam int IMG_H           = 720;
  localparam int FLUSH_CYCLES    = 60;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int PRESSURE_AT     = 160;
  localparam int PRESSURE_CYCLES = 400;
  localparam int LIMIT_TIME      = 800_000;
  localparam int DIR_N           = 25;
  localparam int PHASE_N         = 7;

  localparam coef_t COEF_MAX = 32'h7FFF_FFFF;
  localparam coef_t COEF_MIN = 32'h8000_0000;

  // calibration values the block must come out of reset with
  localparam coef_arr_t CAL_COEF = '{
    32'sd1048601, -32'sd225,    32'sd8620,   -32'sd18510075,
    32'sd69,      32'sd1048480, 32'sd362043, -32'sd7408
  };

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   first;
    logic [COL_W-1:0]   last;
    logic [DEPTH_W-1:0] depth;
  } span_t;

  typedef enum logic [2:0] {
    SET_CAL, SET_UNIT, SET_EXT_LIN, SET_EXT_INV, SET_JITTER, SET_WILD
  } setting_e;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_SPAN} check_e;

  typedef struct packed {
    setting_e           setting;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [DEPTH_W-1:0] depth;
    logic               fs;
    check_e             chk;
    span_t              span;
  } pixel_row_t;

  localparam span_t NO_SPAN = '0;

  // directed pixels: calibration, unit mapping, linear and inverse-depth extremes
  pixel_row_t directed_rows [DIR_N] = '{
    '{SET_CAL,     11'd640,  10'd360,  16'd30000, 1'b1, CHK_MODEL, NO_SPAN},
    '{SET_CAL,     11'd641,  10'd360,  16'd30000, 1'b0, CHK_MODEL, NO_SPAN},
    '{SET_CAL,     11'd700,  10'd361,  16'd65535, 1'b0, CHK_MODEL, NO_SPAN},
    '{SET_CAL,     11'd0,    10'd0,    16'd65535, 1'b0, CHK_NONE,  NO_SPAN},
    '{SET_CAL,     11'd1279, 10'd719,  16'd1,     1'b0, CHK_NONE,  NO_SPAN},
    '{SET_CAL,     11'd1000, 10'd500,  16'd0,     1'b0, CHK_NONE,  NO_SPAN},
    '{SET_UNIT,    11'd5,    10'd3,    16'd100,   1'b1, CHK_SPAN,
      '{10'd3, 11'd1, 11'd5, 16'd100}},
    '{SET_UNIT,    11'd6,    10'd3,    16'd65535, 1'b0, CHK_SPAN,
      '{10'd3, 11'd6, 11'd6, 16'd65535}},
    '{SET_UNIT,    11'd2,    10'd3,    16'd1,     1'b0, CHK_SPAN,
      '{10'd3, 11'd2, 11'd2, 16'd1}},
    '{SET_UNIT,    11'd1279, 10'd719,  16'd65535, 1'b0, CHK_SPAN,
      '{10'd719, 11'd3, 11'd1279, 16'd65535}},
    '{SET_UNIT,    11'd0,    10'd0,    16'd0,     1'b1, CHK_NONE,  NO_SPAN},
    '{SET_UNIT,    11'd2,    10'd0,    16'd1,     1'b0, CHK_SPAN,
      '{10'd0, 11'd1, 11'd2, 16'd1}},
    '{SET_UNIT,    11'd2047, 10'd5,    16'd9,     1'b0, CHK_NONE,  NO_SPAN},
    '{SET_UNIT,    11'd10,   10'd1023, 16'd9,     1'b0, CHK_NONE,  NO_SPAN},
    '{SET_UNIT,    11'd1280, 10'd0,    16'd9,     1'b0, CHK_NONE,  NO_SPAN},
    '{SET_UNIT,    11'd3,    10'd720,  16'd9,     1'b0, CHK_NONE,  NO_SPAN},
    '{SET_UNIT,    11'd5,    10'd719,  16'd65535, 1'b0, CHK_SPAN,
      '{10'd719, 11'd3, 11'd5, 16'd65535}},
    '{SET_UNIT,    11'd0,    10'd719,  16'd2,     1'b1, CHK_SPAN,
      '{10'd719, 11'd0, 11'd0, 16'd2}},
    '{SET_EXT_LIN, 11'd1,    10'd1,    16'd50,    1'b1, CHK_SPAN,
      '{10'd0, 11'd0, 11'd0, 16'd50}},
    '{SET_EXT_LIN, 11'd0,    10'd1,    16'd50,    1'b0, CHK_NONE,  NO_SPAN},
    '{SET_EXT_LIN, 11'd1,    10'd2,    16'd65535, 1'b0, CHK_NONE,  NO_SPAN},
    '{SET_EXT_LIN, 11'd1,    10'd1,    16'd65535, 1'b0, CHK_SPAN,
      '{10'd0, 11'd0, 11'd0, 16'd65535}},
    '{SET_EXT_INV, 11'd0,    10'd0,    16'd65535, 1'b1, CHK_MODEL, NO_SPAN},
    '{SET_EXT_INV, 11'd5,    10'd5,    16'd65534, 1'b0, CHK_MODEL, NO_SPAN},
    '{SET_EXT_INV, 11'd0,    10'd0,    16'd1000,  1'b0, CHK_MODEL, NO_SPAN}
  };

  setting_e phase_setting [PHASE_N] = '{
    SET_JITTER, SET_EXT_LIN, SET_CAL, SET_WILD, SET_EXT_INV, SET_JITTER, SET_UNIT
  };
  int phase_items [PHASE_N] = '{80, 25, 80, 20, 25, 80, 70};

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr_i    = '0;
  logic [COEF_W-1:0]      cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // src_col [10:0], src_row [20:11], depth_value [36:21], zero fill [39:37]
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  // frame_start [0]
  logic [0:0]             s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // dst_row [9:0], span_first [20:10], span_last [31:21], span_depth [47:32]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // predictor state and checking bookkeeping
  coef_t            coef_model [NUM_COEF];
  logic [COL_W-1:0] last_col_model;
  span_t            span_queue [$];
  int               failures        = 0;
  int               pixels_accepted = 0;
  int               spans_checked   = 0;
  int               settings_loaded = 0;
  int               burst_left      = 0;

  // receiver stall state
  int               hold_left     = 0;
  int               mode_left     = 0;
  int               tick          = 0;
  bit               pressure_done = 1'b0;
  logic [7:0]       stall_mask    = 8'hFF;
  span_t            seen_span, wanted_span;

  depth_to_color_registration #(
    .IMG_WIDTH (IMG_W),
    .IMG_HEIGHT(IMG_H)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #LIMIT_TIME;
    $display("depth_to_color_registration regression: fail");
    $finish;
  end

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  // one axis: weighted column, row and offset plus weighted inverse depth, to whole pixels
  function automatic longint axis_coord(input coef_t w_col, input coef_t w_row,
                                        input coef_t w_off, input coef_t w_inv,
                                        input longint col, input longint row,
                                        input logic [INV_W-1:0] inv);
    longint unsigned mag;
    longint unsigned scaled;
    longint          inv_part;
    longint          acc;
    mag      = (w_inv < 0) ? -longint'(w_inv) : longint'(w_inv);
    scaled   = (mag * {32'd0, inv}) >> INV_SHIFT;
    inv_part = (w_inv < 0) ? -longint'(scaled) : longint'(scaled);
    acc      = longint'(w_col) * col + longint'(w_row) * row + longint'(w_off) + inv_part;
    return acc / longint'(1 << FRAC_W);
  endfunction

  // span a pixel writes, if any; advances the last mapped column
  function automatic bit map_pixel_span(input logic [COL_W-1:0] col,
                                        input logic [ROW_W-1:0] row,
                                        input logic [DEPTH_W-1:0] depth,
                                        input logic fs, output span_t sp);
    logic [INV_W-1:0] inv;
    longint           u, v, first_col, next_col;
    sp = NO_SPAN;
    if (fs) last_col_model = '0;
    if (depth == '0) return 1'b0;
    inv = INV_NUM / {16'd0, depth};
    u = axis_coord(coef_model[REG_COL_FROM_COL], coef_model[REG_COL_FROM_ROW],
                   coef_model[REG_COL_OFFSET], coef_model[REG_COL_INV_DEPTH],
                   longint'(col), longint'(row), inv);
    v = axis_coord(coef_model[REG_ROW_FROM_COL], coef_model[REG_ROW_FROM_ROW],
                   coef_model[REG_ROW_OFFSET], coef_model[REG_ROW_INV_DEPTH],
                   longint'(col), longint'(row), inv);
    if (u < 0 || u >= IMG_W || v < 0 || v >= IMG_H) return 1'b0;
    next_col  = longint'(last_col_model) + 1;
    first_col = (u > next_col) ? next_col : u;
    last_col_model = u[COL_W-1:0];
    sp.row   = v[ROW_W-1:0];
    sp.first = first_col[COL_W-1:0];
    sp.last  = u[COL_W-1:0];
    sp.depth = depth;
    return 1'b1;
  endfunction

  function automatic logic [DEPTH_W-1:0] pick_depth(input bit near);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 12) return DEPTH_W'($urandom_range(1, 255));
    if (r < 22) return DEPTH_W'($urandom_range(1, 65535));
    if (near) return 16'hFFFF - DEPTH_W'($urandom_range(3));
    return DEPTH_W'($urandom_range(1500, 65535));
  endfunction

  // offer one pixel in bursts with random gaps, then book its expected span
  task automatic offer_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                             input logic [DEPTH_W-1:0] depth, input logic fs,
                             input check_e chk, input span_t typed);
    span_t predicted;
    bit    hit;
    int    gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 60);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({depth, row, col});
    s_axis_tuser  <= fs;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    pixels_accepted++;
    hit = map_pixel_span(col, row, depth, fs, predicted);
    case (chk)
      CHK_MODEL: if (hit) span_queue = {span_queue, predicted};
      CHK_SPAN:  span_queue = {span_queue, typed};
      default:   ;
    endcase
  endtask

  // stop offering and let the block go idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (span_queue.size() != 0) @(posedge clk_i);
    repeat (FLUSH_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_setting(input setting_e s);
    coef_arr_t vals;
    int        i;
    settle();
    vals = CAL_COEF;
    case (s)
      SET_UNIT: begin
        foreach (vals[k]) vals[k] = '0;
        vals[REG_COL_FROM_COL] = coef_t'(1 << FRAC_W);
        vals[REG_ROW_FROM_ROW] = coef_t'(1 << FRAC_W);
      end
      SET_EXT_LIN: begin
        foreach (vals[k]) vals[k] = '0;
        vals[REG_COL_FROM_COL] = COEF_MAX;
        vals[REG_COL_OFFSET]   = COEF_MIN;
        vals[REG_ROW_FROM_ROW] = COEF_MAX;
        vals[REG_ROW_OFFSET]   = COEF_MIN;
      end
      SET_EXT_INV: begin
        foreach (vals[k]) vals[k] = '0;
        vals[REG_COL_OFFSET]    = COEF_MAX;
        vals[REG_COL_INV_DEPTH] = COEF_MIN;
        vals[REG_ROW_OFFSET]    = COEF_MIN;
        vals[REG_ROW_INV_DEPTH] = COEF_MAX;
      end
      SET_JITTER: begin
        vals[REG_COL_FROM_COL]  = coef_t'((1 << FRAC_W) + int'($urandom_range(16384)) - 8192);
        vals[REG_COL_FROM_ROW]  = coef_t'(int'($urandom_range(4096)) - 2048);
        vals[REG_COL_OFFSET]    = coef_t'(int'($urandom_range(80 << FRAC_W)) - (40 << FRAC_W));
        vals[REG_COL_INV_DEPTH] = coef_t'(-int'($urandom_range(30 << FRAC_W)));
        vals[REG_ROW_FROM_COL]  = coef_t'(int'($urandom_range(4096)) - 2048);
        vals[REG_ROW_FROM_ROW]  = coef_t'((1 << FRAC_W) + int'($urandom_range(16384)) - 8192);
        vals[REG_ROW_OFFSET]    = coef_t'(int'($urandom_range(40 << FRAC_W)) - (20 << FRAC_W));
        vals[REG_ROW_INV_DEPTH] = coef_t'(int'($urandom_range(2 << FRAC_W)) - (1 << FRAC_W));
      end
      SET_WILD: begin
        foreach (vals[k]) vals[k] = coef_t'($urandom);
      end
      default: ;
    endcase
    // one register per cycle, block is idle
    for (i = 0; i < NUM_COEF; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_addr_i <= cfg_reg_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      coef_model[i] = vals[i];
    end
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  // raster runs with random content, mixed with unconstrained noise pixels
  task automatic run_random(input setting_e s, input int count);
    int               sent, run_len, i, next_col, step;
    bit               near;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             fs;
    sent = 0;
    near = (s == SET_EXT_LIN) || (s == SET_EXT_INV);
    while (sent < count) begin
      if ($urandom_range(99) < 15) begin
        offer_pixel(COL_W'($urandom_range(2047)), ROW_W'($urandom_range(1023)),
                    DEPTH_W'($urandom_range(65535)), 1'($urandom_range(1)),
                    CHK_MODEL, NO_SPAN);
        sent++;
      end else begin
        row     = near ? ROW_W'($urandom_range(3)) : ROW_W'($urandom_range(IMG_H - 1));
        col     = near ? COL_W'($urandom_range(3)) : COL_W'($urandom_range(IMG_W - 1));
        fs      = ($urandom_range(3) == 0);
        run_len = $urandom_range(1, 16);
        for (i = 0; i < run_len && sent < count; i++) begin
          offer_pixel(col, row, pick_depth(near), fs, CHK_MODEL, NO_SPAN);
          fs = 1'b0;
          sent++;
          step = $urandom_range(9);
          if (near) next_col = $urandom_range(3);
          else if (step < 6) next_col = int'(col) + 1;
          else if (step < 8) next_col = int'(col) + $urandom_range(2, 40);
          else if (step == 8) next_col = int'(col);
          else next_col = int'(col) - $urandom_range(1, 5);
          if (next_col < 0 || next_col >= IMG_W) break;
          col = COL_W'(next_col);
        end
      end
    end
  endtask

  // span transactions: check against the oldest expectation, then pick the next ready
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      seen_span.row   = m_axis_tdata[OUT_ROW_LSB +: ROW_W];
      seen_span.first = m_axis_tdata[OUT_FIRST_LSB +: COL_W];
      seen_span.last  = m_axis_tdata[OUT_LAST_LSB +: COL_W];
      seen_span.depth = m_axis_tdata[OUT_DEPTH_LSB +: DEPTH_W];
      spans_checked++;
      if (span_queue.size() == 0) begin
        note_failure($sformatf("unexpected span row %0d cols %0d..%0d depth %0d",
                               seen_span.row, seen_span.first, seen_span.last,
                               seen_span.depth));
      end else begin
        wanted_span = span_queue.pop_front();
        if (seen_span.row !== wanted_span.row || seen_span.first !== wanted_span.first ||
            seen_span.last !== wanted_span.last || seen_span.depth !== wanted_span.depth)
          note_failure($sformatf(
            "span mismatch: expected row %0d cols %0d..%0d depth %0d, got row %0d cols %0d..%0d depth %0d",
            wanted_span.row, wanted_span.first, wanted_span.last, wanted_span.depth,
            seen_span.row, seen_span.first, seen_span.last, seen_span.depth));
      end
    end
    // one long hold-off so the block backs up into its input
    if (!pressure_done && pixels_accepted >= PRESSURE_AT) begin
      hold_left     = PRESSURE_CYCLES;
      pressure_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mask = ($urandom_range(2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      tick++;
      m_axis_tready <= rst_ni & stall_mask[tick % 8];
    end
  end

  initial begin
    int     p, waited, leftover;
    setting_e current;
    coef_model     = CAL_COEF;
    last_col_model = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pixels, reloading coefficients when the row asks for another setting
    current = SET_CAL;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].setting != current) begin
        load_setting(directed_rows[r].setting);
        current = directed_rows[r].setting;
      end
      offer_pixel(directed_rows[r].col, directed_rows[r].row, directed_rows[r].depth,
                  directed_rows[r].fs, directed_rows[r].chk, directed_rows[r].span);
    end

    for (p = 0; p < PHASE_N; p++) begin
      load_setting(phase_setting[p]);
      run_random(phase_setting[p], phase_items[p]);
    end

    // drain with a bound, then let any stray span show up
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (span_queue.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (FLUSH_CYCLES) @(posedge clk_i);
    leftover = span_queue.size();
    if (leftover != 0) note_failure($sformatf("%0d expected spans never arrived", leftover));

    $display("covered %0d pixels under %0d coefficient loads, %0d spans checked",
             pixels_accepted, settings_loaded, spans_checked);
    $display("including a %0d cycle output stall and %0d failures", PRESSURE_CYCLES, failures);
    if (failures == 0) begin
      $display("depth_to_color_registration regression: pass");
    end else begin
      $display("depth_to_color_registration regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/d2c_pkg.sv
sv/d2c_div.sv
sv/d2c_dp.sv
sv/d2c_ctrl.sv
sv/depth_to_color_registration.sv
test/tb.sv
